### src/sib_pkg.sv
// shared types and constants for the sorted insertion buffer
package sib_pkg;

  localparam int DataW        = 32;
  localparam int PosW         = 5;
  localparam int DefaultDepth = 32;

  typedef enum logic [1:0] {
    CellHold,
    CellInsert,
    CellRotate
  } cell_op_e;

  typedef enum logic {
    StIdle,
    StList
  } sib_state_e;

  typedef struct packed {
    cell_op_e                  op;
    logic signed [DataW-1:0]   ins_value;
  } cell_ctrl_t;

endpackage

### src/sib_cell.sv
// one storage cell of the sorted chain: insert-shift and listing rotation
module sib_cell (
  input  logic                           clk_i,
  input  sib_pkg::cell_ctrl_t            ctrl_i,
  input  logic                           occupied_i,
  input  logic                           wrap_i,
  input  logic                           prev_gt_i,
  input  logic signed [sib_pkg::DataW-1:0] prev_value_i,
  input  logic signed [sib_pkg::DataW-1:0] next_value_i,
  input  logic signed [sib_pkg::DataW-1:0] ring_value_i,
  output logic                           gt_o,
  output logic signed [sib_pkg::DataW-1:0] value_o
);
  import sib_pkg::*;

  logic signed [DataW-1:0] value_q, value_d;

  // new value sorts after this entry
  assign gt_o = occupied_i && (ctrl_i.ins_value > value_q);

  always_comb begin
    value_d = value_q;
    case (ctrl_i.op)
      CellInsert: begin
        if (gt_o) begin
          value_d = value_q;
        end else if (prev_gt_i) begin
          value_d = ctrl_i.ins_value;
        end else begin
          value_d = prev_value_i;
        end
      end
      CellRotate: begin
        // the last occupied cell takes the head so the list comes back in place
        value_d = wrap_i ? ring_value_i : next_value_i;
      end
      default: value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

### src/sib_ctrl.sv
// sequencer: entry count, listing position and cell commands
module sib_ctrl #(
  parameter int DEPTH = sib_pkg::DefaultDepth,
  localparam int CntW = $clog2(DEPTH + 1)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic signed [sib_pkg::DataW-1:0] value_i,
  input  logic                            out_stall_i,
  output logic                            in_stall_o,
  output logic                            out_valid_o,
  output logic                            last_o,
  output logic                            rejected_o,
  output logic [CntW-1:0]                 count_o,
  output logic [CntW-1:0]                 pos_o,
  output sib_pkg::cell_ctrl_t             cell_ctrl_o
);
  import sib_pkg::*;

  sib_state_e      state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] pos_q, pos_d;
  logic            rej_q, rej_d;
  logic            full;
  logic            in_xfer;
  logic            out_xfer;

  assign full     = (count_q == CntW'(DEPTH));
  assign in_xfer  = in_valid_i && (state_q == StIdle);
  assign out_xfer = (state_q == StList) && !out_stall_i;
  assign last_o   = (pos_q == count_q - CntW'(1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (in_valid_i) state_d = StList;
      StList:  if (!out_stall_i && last_o) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    count_d = count_q;
    pos_d   = pos_q;
    rej_d   = rej_q;
    if (in_xfer) begin
      pos_d = '0;
      rej_d = full;
      if (!full) count_d = count_q + CntW'(1);
    end else if (out_xfer) begin
      pos_d = pos_q + CntW'(1);
    end
  end

  always_comb begin
    in_stall_o            = (state_q != StIdle);
    out_valid_o           = (state_q == StList);
    cell_ctrl_o.ins_value = value_i;
    if (in_xfer && !full) begin
      cell_ctrl_o.op = CellInsert;
    end else if (out_xfer) begin
      cell_ctrl_o.op = CellRotate;
    end else begin
      cell_ctrl_o.op = CellHold;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      count_q <= '0;
      pos_q   <= '0;
      rej_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pos_q   <= pos_d;
      rej_q   <= rej_d;
    end
  end

  assign rejected_o = rej_q;
  assign count_o    = count_q;
  assign pos_o      = pos_q;

endmodule

### src/sorted_insertion_buffer.sv
// top level of the sorted insertion buffer: chain of cells plus sequencer
//
//  channel | handshake               | payload
//  --------+-------------------------+---------------------------------------
//  in      | in_valid_i / in_stall_o | value_i
//  out     | out_valid_o/ out_stall_i| element_o, position_o, last_o, rejected_o
//
// an item is inserted across the cell chain when it is accepted (a full store
// rejects it instead), then the ring of cells rotates one entry per output
// transfer to list every stored entry, from the head.
// reset empties the store; entries are loaded only by inserts.
// a stall on the output freezes the rotation, so the head entry holds.
module sorted_insertion_buffer #(
  parameter int DEPTH = sib_pkg::DefaultDepth
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic signed [sib_pkg::DataW-1:0] value_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [sib_pkg::DataW-1:0] element_o,
  output logic [sib_pkg::PosW-1:0]         position_o,
  output logic                             last_o,
  output logic                             rejected_o
);
  import sib_pkg::*;

  localparam int CntW = $clog2(DEPTH + 1);

  cell_ctrl_t              cell_ctrl;
  logic [CntW-1:0]         count;
  logic [CntW-1:0]         pos;
  logic signed [DataW-1:0] cell_val [DEPTH];
  logic                    cell_gt  [DEPTH];

  sib_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .value_i     (value_i),
    .out_stall_i (out_stall_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .last_o      (last_o),
    .rejected_o  (rejected_o),
    .count_o     (count),
    .pos_o       (pos),
    .cell_ctrl_o (cell_ctrl)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                    prev_gt;
    logic signed [DataW-1:0] prev_value;
    logic signed [DataW-1:0] next_value;

    if (i == 0) begin : g_head
      assign prev_gt    = 1'b1;
      assign prev_value = cell_ctrl.ins_value;
    end else begin : g_body
      assign prev_gt    = cell_gt[i-1];
      assign prev_value = cell_val[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_value = cell_val[0];
    end else begin : g_mid
      assign next_value = cell_val[i+1];
    end

    sib_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (cell_ctrl),
      .occupied_i   (CntW'(i) < count),
      .wrap_i       (CntW'(i + 1) == count),
      .prev_gt_i    (prev_gt),
      .prev_value_i (prev_value),
      .next_value_i (next_value),
      .ring_value_i (cell_val[0]),
      .gt_o         (cell_gt[i]),
      .value_o      (cell_val[i])
    );
  end

  assign element_o  = cell_val[0];
  assign position_o = PosW'(pos);

  // one item at a time: no new input while a listing is pending
  a_no_overlap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken during a listing");

  a_accept_lists : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (out_valid_o && position_o == '0))
    else $error("accepted input did not start a listing");

  a_last_ends : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && last_o) |=> !out_valid_o)
    else $error("listing continued past its last entry");

  a_reject_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && rejected_o) |-> (count == CntW'(DEPTH)))
    else $error("rejection flagged with room in the store");

endmodule

### sim/sorted_insertion_buffer_test.sv
// self-checking testbench for the sorted insertion buffer
module sorted_insertion_buffer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sib_pkg::*;

  localparam int Depth      = DefaultDepth;
  localparam int NumRandom  = 180;
  localparam int BurstMax   = 14;
  localparam int HoldCycles = 300;
  localparam int HoldAfter  = 400;
  localparam int QuietTail  = 30;
  localparam int IdleLimit  = 5000;
  localparam int DrainWait  = 2 * Depth + 16;
  localparam int MaxReports = 60;

  localparam logic signed [DataW-1:0] Corners [18] = '{
    32'sh0000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 32'shffff_ffff,
    32'sh0000_0001, 32'sh0000_0000, 32'sh7fff_ffff, 32'sh8000_0000,
    32'sh0000_0005, -32'sd5,        32'sh5555_5555, 32'shaaaa_aaaa,
    32'sh0f0f_0f0f, 32'shf0f0_f0f0, 32'sh1234_5678, 32'shedcb_a987,
    32'sh8000_0001, 32'sh7fff_fffe
  };

  typedef struct {
    logic signed [DataW-1:0] element;
    logic [PosW-1:0]         position;
    logic                    last;
    logic                    rejected;
  } listing_entry_t;

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    in_valid_i  = 1'b0;
  logic                    in_stall_o;
  logic signed [DataW-1:0] value_i     = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic signed [DataW-1:0] element_o;
  logic [PosW-1:0]         position_o;
  logic                    last_o;
  logic                    rejected_o;

  // predictor state: sorted copy of the store and its fill level
  logic signed [DataW-1:0] model_store [Depth];
  int                      model_count = 0;

  logic signed [DataW-1:0] value_queue [$];
  listing_entry_t          listing_q [$];

  int          inserts_done    = 0;
  int          drops_done      = 0;
  int          results_checked = 0;
  int          error_count     = 0;
  int          idle_cycles     = 0;
  int          in_gap          = 0;
  int          out_hold        = 0;
  logic        in_xfer         = 1'b0;
  logic        pressure_done   = 1'b0;
  logic [31:0] cycle_cnt       = '0;

  sorted_insertion_buffer #(
    .DEPTH(Depth)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .element_o   (element_o),
    .position_o  (position_o),
    .last_o      (last_o),
    .rejected_o  (rejected_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // insert one value (or drop it when full) and queue the listing that follows
  function automatic void insert_and_list(logic signed [DataW-1:0] v);
    int             slot;
    logic           dropped;
    listing_entry_t ent;
    slot    = 0;
    dropped = (model_count >= Depth);
    if (dropped) begin
      drops_done++;
    end else begin
      while (slot < model_count && v > model_store[slot]) slot++;
      for (int k = model_count; k > slot; k--) model_store[k] = model_store[k-1];
      model_store[slot] = v;
      model_count++;
      inserts_done++;
    end
    for (int k = 0; k < model_count; k++) begin
      ent.element  = model_store[k];
      ent.position = PosW'(k);
      ent.last     = (k + 1 == model_count);
      ent.rejected = dropped;
      listing_q.push_back(ent);
    end
  endfunction

  function automatic void check_field(string name, logic signed [DataW-1:0] exp_v,
                                      logic signed [DataW-1:0] got_v);
    if (got_v !== exp_v) begin
      error_count++;
      if (error_count <= MaxReports)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
      else if (error_count == MaxReports + 1)
        $display("%0t: further mismatches not shown", $time);
    end
  endfunction

  function automatic logic idling_allowed();
    return value_queue.size() >= QuietTail && cycle_cnt[9:8] != 2'b11;
  endfunction

  // monitor: checks output transfers, feeds input transfers to the predictor
  always @(posedge clk_i) begin
    listing_entry_t want;
    logic           out_xfer;
    if (rst_ni) begin
      cycle_cnt <= cycle_cnt + 1;
      out_xfer = out_valid_o && !out_stall_i;
      if (out_xfer) begin
        results_checked++;
        if (listing_q.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result, expected none, got element %0d position %0d",
                   $time, element_o, position_o);
        end else begin
          want = listing_q.pop_front();
          check_field("element", want.element, element_o);
          check_field("position", DataW'(want.position), DataW'(position_o));
          check_field("last", DataW'(want.last), DataW'(last_o));
          check_field("rejected", DataW'(want.rejected), DataW'(rejected_o));
        end
      end
      in_xfer = in_valid_i && !in_stall_o;
      if (in_xfer) begin
        insert_and_list(value_i);
        void'(value_queue.pop_front());
      end
      if (in_xfer || out_xfer) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("%0t: timeout, no transfer for %0d cycles", $time, IdleLimit);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // sender: holds an offered value until its transfer, random gaps between items
  always @(negedge clk_i) begin
    logic next_valid;
    next_valid = in_valid_i;
    if (!rst_ni) begin
      next_valid = 1'b0;
    end else if (!in_valid_i || in_xfer) begin
      if (in_gap > 0) begin
        in_gap--;
        next_valid = 1'b0;
      end else if (value_queue.size() == 0) begin
        next_valid = 1'b0;
      end else if (idling_allowed() && $urandom_range(0, 5) == 0) begin
        in_gap     = $urandom_range(1, BurstMax) - 1;
        next_valid = 1'b0;
      end else begin
        next_valid = 1'b1;
        value_i <= value_queue[0];
      end
    end
    in_valid_i <= next_valid;
  end

  // receiver: random stall bursts plus one long hold-off to back up the input
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (!pressure_done && results_checked >= HoldAfter) begin
      pressure_done = 1'b1;
      out_hold      = HoldCycles - 1;
      out_stall_i <= 1'b1;
    end else if (out_hold > 0) begin
      out_hold--;
      out_stall_i <= 1'b1;
    end else if (idling_allowed() && $urandom_range(0, 5) == 0) begin
      out_hold = $urandom_range(1, BurstMax) - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  initial begin
    logic signed [DataW-1:0] v;
    foreach (Corners[i]) value_queue.push_back(Corners[i]);
    // small values give many equal keys, corners hit the ends of the order
    for (int n = 0; n < NumRandom; n++) begin
      case ($urandom_range(0, 7))
        0, 1:    v = int'($urandom_range(0, 16)) - 8;
        2:       v = $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
        default: v = $urandom();
      endcase
      value_queue.push_back(v);
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (value_queue.size() != 0 || listing_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    if (listing_q.size() != 0) begin
      error_count++;
      $display("%0t: %0d listing entries never arrived", $time, listing_q.size());
    end
    $display("stored %0d values, dropped %0d on a full store, checked %0d listing entries",
             inserts_done, drops_done, results_checked);
    $display("long output hold-off %s", pressure_done ? "applied" : "not reached");
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
